[src/gpj_pkg.sv]
// ----------------------------------------------------------------------------
// gpj_pkg : shared constants and helpers for the gamepad report converter
// Report layout offsets, stick centre, d-pad bit masks and hat decoding.
// ----------------------------------------------------------------------------
package gpj_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DIR_W   = 4;
	localparam int unsigned DZONE_W = 7;
	localparam int unsigned HAT_W   = 4;

	localparam logic [BYTE_W-1:0]  ID_BYTE       = 8'h01;
	localparam logic [BYTE_W-1:0]  STICK_CENTRE  = 8'd128;
	localparam logic [BYTE_W-1:0]  MIN_LEN_M1    = 8'd19;   // length 20 minus the final byte
	localparam logic [BYTE_W-1:0]  COUNT_MAX     = 8'd255;
	localparam logic [DZONE_W-1:0] DEAD_ZONE_RST = 7'd50;

	// data positions after the optional report ID
	localparam logic [BYTE_W-1:0] POS_DPAD = 8'd1;
	localparam logic [BYTE_W-1:0] POS_FACE = 8'd2;
	localparam logic [BYTE_W-1:0] POS_LX   = 8'd5;
	localparam logic [BYTE_W-1:0] POS_LY   = 8'd6;
	localparam logic [BYTE_W-1:0] POS_RX   = 8'd7;
	localparam logic [BYTE_W-1:0] POS_RY   = 8'd8;

	// d-pad and face byte masks
	localparam logic [BYTE_W-1:0] DPAD_UP    = 8'h10;
	localparam logic [BYTE_W-1:0] DPAD_RIGHT = 8'h20;
	localparam logic [BYTE_W-1:0] DPAD_DOWN  = 8'h40;
	localparam logic [BYTE_W-1:0] DPAD_LEFT  = 8'h80;
	localparam logic [BYTE_W-1:0] FACE_CROSS  = 8'h40;
	localparam logic [BYTE_W-1:0] FACE_CIRCLE = 8'h20;

	localparam logic [HAT_W-1:0] HAT_CENTRED = 4'd8;

	// direction bits: 0 up, 1 down, 2 left, 3 right
	localparam logic [DIR_W-1:0] DIR_UP         = 4'h1;
	localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'h9;
	localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'h8;
	localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'hA;
	localparam logic [DIR_W-1:0] DIR_DOWN       = 4'h2;
	localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'h6;
	localparam logic [DIR_W-1:0] DIR_LEFT       = 4'h4;
	localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'h5;

	// d-pad bits to hat: up over down over right over left
	function automatic logic [HAT_W-1:0] hat_of(input logic [BYTE_W-1:0] d);
		logic [HAT_W-1:0] h;
		if ((d & DPAD_UP) != '0) begin
			if ((d & DPAD_RIGHT) != '0)     h = 4'd1;
			else if ((d & DPAD_LEFT) != '0) h = 4'd7;
			else                            h = 4'd0;
		end else if ((d & DPAD_DOWN) != '0) begin
			if ((d & DPAD_RIGHT) != '0)     h = 4'd3;
			else if ((d & DPAD_LEFT) != '0) h = 4'd5;
			else                            h = 4'd4;
		end else if ((d & DPAD_RIGHT) != '0) begin
			h = 4'd2;
		end else if ((d & DPAD_LEFT) != '0) begin
			h = 4'd6;
		end else begin
			h = HAT_CENTRED;
		end
		return h;
	endfunction

	// hat value (0..7) to direction bits
	function automatic logic [DIR_W-1:0] hat_to_dir(input logic [HAT_W-1:0] h);
		logic [DIR_W-1:0] r;
		case (h[2:0])
			3'd0:    r = DIR_UP;
			3'd1:    r = DIR_UP_RIGHT;
			3'd2:    r = DIR_RIGHT;
			3'd3:    r = DIR_DOWN_RIGHT;
			3'd4:    r = DIR_DOWN;
			3'd5:    r = DIR_DOWN_LEFT;
			3'd6:    r = DIR_LEFT;
			default: r = DIR_UP_LEFT;
		endcase
		return r;
	endfunction

endpackage

[src/gpj_in_if.sv]
// ----------------------------------------------------------------------------
// gpj_in_if : report byte stream channel
// One report byte per beat, with a flag on the final byte of a report.
// ----------------------------------------------------------------------------
interface gpj_in_if import gpj_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] report_byte;
	logic              report_end;

	modport source (output valid, output report_byte, output report_end, input ready);
	modport sink   (input valid, input report_byte, input report_end, output ready);
endinterface

[src/gpj_out_if.sv]
// ----------------------------------------------------------------------------
// gpj_out_if : joystick result channel
// One beat per finished report: two directions, two fire bits, commit flag.
// ----------------------------------------------------------------------------
interface gpj_out_if import gpj_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DIR_W-1:0] left_direction;
	logic             main_fire;
	logic [DIR_W-1:0] right_direction;
	logic             second_fire;
	logic             report_accepted;

	modport source (output valid, output left_direction, output main_fire,
		output right_direction, output second_fire, output report_accepted,
		input ready);
	modport sink (input valid, input left_direction, input main_fire,
		input right_direction, input second_fire, input report_accepted,
		output ready);
endinterface

[src/gpj_stick_dir.sv]
// ----------------------------------------------------------------------------
// gpj_stick_dir : stick position to direction bits
// Compares both axes against centre plus and minus the dead zone.
// ----------------------------------------------------------------------------
module gpj_stick_dir import gpj_pkg::*; (
	input  logic [BYTE_W-1:0]  x,
	input  logic [BYTE_W-1:0]  y,
	input  logic [DZONE_W-1:0] dead_zone,
	output logic [DIR_W-1:0]   dir
);

	logic [BYTE_W-1:0] lo_lim;
	logic [BYTE_W-1:0] hi_lim;

	// centre 128 and dead zone below 128 keep both limits inside a byte
	assign lo_lim = STICK_CENTRE - {1'b0, dead_zone};
	assign hi_lim = STICK_CENTRE + {1'b0, dead_zone};

	// set one bit per exceeded limit
	assign dir[0] = (y < lo_lim);
	assign dir[1] = (y > hi_lim);
	assign dir[2] = (x < lo_lim);
	assign dir[3] = (x > hi_lim);

endmodule

[src/gamepad_report_to_joystick.sv]
// ----------------------------------------------------------------------------
// gamepad_report_to_joystick : gamepad input report to joystick directions
// Parses a byte stream of gamepad reports and returns directions and fire bits.
// ----------------------------------------------------------------------------
// Usage:
//   report_in carries one report byte per beat; report_end marks the final
//   byte. A leading 0x01 is taken as a report ID and skipped. D-pad, face
//   and stick bytes are captured per report and committed at its end when
//   the report is at least 20 bytes long; shorter reports keep old values.
//   joy_out gives one beat per final byte: left and right directions, two
//   fire bits and report_accepted. No beat is given for other bytes.
//   cfg_we/cfg_wdata write the stick dead zone; write only while idle.
// Timing:
//   One byte per cycle sustained unless a final byte meets a held result.
//   A byte is held in the input register, then the parse and commit logic
//   loads the result register from it, which drives joy_out.
// Reset and stall:
//   Reset centres the sticks, releases the d-pad, clears the face buttons
//   and the byte counter, and sets the dead zone to 50. While joy_out is
//   stalled with a result held, non-final bytes still flow; a final byte
//   waits in the input register until the held result is taken.
// ----------------------------------------------------------------------------
module gamepad_report_to_joystick import gpj_pkg::*; #(
	parameter logic [DZONE_W-1:0] DEAD_ZONE_RESET = DEAD_ZONE_RST
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [DZONE_W-1:0] cfg_wdata,
	gpj_in_if.sink             report_in,
	gpj_out_if.source          joy_out
);

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                end_s1;
	logic                advance_s1;

	logic [DZONE_W-1:0]  dead_zone_q;
	logic [BYTE_W-1:0]   count_q;
	logic                has_id_q;
	logic [BYTE_W-1:0]   shadow_q [6];
	logic [HAT_W-1:0]    hat_q;
	logic [BYTE_W-1:0]   face_q;
	logic [BYTE_W-1:0]   stick_q [4];

	logic                id_now;
	logic [BYTE_W-1:0]   dpos;
	logic                in_data;
	logic                commit;
	logic [HAT_W-1:0]    hat_nx;
	logic [BYTE_W-1:0]   face_nx;
	logic [BYTE_W-1:0]   stick_nx [4];
	logic [DIR_W-1:0]    left_stick_dir;
	logic [DIR_W-1:0]    right_stick_dir;
	logic [DIR_W-1:0]    left_dir;

	logic                out_valid_q;
	logic [DIR_W-1:0]    left_q;
	logic                main_q;
	logic [DIR_W-1:0]    right_q;
	logic                second_q;
	logic                acc_q;

	// advance the input register unless a final byte meets a held result
	assign advance_s1      = valid_s1 && (!end_s1 || !out_valid_q || joy_out.ready);
	assign report_in.ready = !valid_s1 || advance_s1;

	// hold one input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (report_in.ready) begin
			valid_s1 <= report_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (report_in.ready && report_in.valid) begin
			byte_s1 <= report_in.report_byte;
			end_s1  <= report_in.report_end;
		end
	end

	// dead zone register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= DEAD_ZONE_RESET;
		end else if (cfg_we) begin
			dead_zone_q <= cfg_wdata;
		end
	end

	// locate the byte within the report data
	assign id_now  = has_id_q || ((count_q == '0) && (byte_s1 == ID_BYTE));
	assign in_data = (count_q >= {{(BYTE_W-1){1'b0}}, id_now});
	assign dpos    = count_q - {{(BYTE_W-1){1'b0}}, id_now};

	// track position and report ID, clear both after a final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			has_id_q <= 1'b0;
		end else if (advance_s1) begin
			if (end_s1) begin
				count_q  <= '0;
				has_id_q <= 1'b0;
			end else begin
				if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
				has_id_q <= id_now;
			end
		end
	end

	// capture shadow fields
	always_ff @(posedge clk) begin
		if (advance_s1 && in_data) begin
			case (dpos)
				POS_DPAD: shadow_q[0] <= byte_s1;
				POS_FACE: shadow_q[1] <= byte_s1;
				POS_LX:   shadow_q[2] <= byte_s1;
				POS_LY:   shadow_q[3] <= byte_s1;
				POS_RX:   shadow_q[4] <= byte_s1;
				POS_RY:   shadow_q[5] <= byte_s1;
				default:  ;
			endcase
		end
	end

	// commit on a final byte of a long enough report
	assign commit  = advance_s1 && end_s1 && (count_q >= MIN_LEN_M1);
	assign hat_nx  = commit ? hat_of(shadow_q[0]) : hat_q;
	assign face_nx = commit ? shadow_q[1] : face_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			stick_nx[i] = commit ? shadow_q[2+i] : stick_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hat_q  <= HAT_CENTRED;
			face_q <= '0;
			for (int i = 0; i < 4; i++) stick_q[i] <= STICK_CENTRE;
		end else if (commit) begin
			hat_q  <= hat_nx;
			face_q <= face_nx;
			for (int i = 0; i < 4; i++) stick_q[i] <= stick_nx[i];
		end
	end

	// stick directions from the values in force after this byte
	gpj_stick_dir u_left_dir (
		.x         (stick_nx[0]),
		.y         (stick_nx[1]),
		.dead_zone (dead_zone_q),
		.dir       (left_stick_dir)
	);

	gpj_stick_dir u_right_dir (
		.x         (stick_nx[2]),
		.y         (stick_nx[3]),
		.dead_zone (dead_zone_q),
		.dir       (right_stick_dir)
	);

	// a pressed d-pad overrides the left stick
	assign left_dir = (hat_nx < HAT_CENTRED) ? hat_to_dir(hat_nx) : left_stick_dir;

	// result register: load on a final byte, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (joy_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && end_s1) begin
			left_q   <= left_dir;
			main_q   <= ((face_nx & FACE_CROSS) != '0);
			right_q  <= right_stick_dir;
			second_q <= ((face_nx & FACE_CIRCLE) != '0);
			acc_q    <= commit;
		end
	end

	assign joy_out.valid           = out_valid_q;
	assign joy_out.left_direction  = left_q;
	assign joy_out.main_fire       = main_q;
	assign joy_out.right_direction = right_q;
	assign joy_out.second_fire     = second_q;
	assign joy_out.report_accepted = acc_q;

	// an empty input register always takes a beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> report_in.ready)
		else $error("input register empty but not ready");

	// a final byte leaves the report state cleared
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && end_s1 |=> (count_q == '0) && !has_id_q)
		else $error("report state not cleared after final byte");

	// the byte counter saturates
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && !end_s1 && (count_q == COUNT_MAX) |=> count_q == COUNT_MAX)
		else $error("byte counter wrapped");

	// a long report yields an accepted result beat
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> joy_out.valid && joy_out.report_accepted)
		else $error("committed report without accepted result");

endmodule
